@@ sv/gspl_pkg.sv @@
// gspl_pkg: shared types, gas table and constants for the gas ppm pipeline
// no dependencies; used by every module of the block
package gspl_pkg;

    // gas selector codes
    localparam logic [2:0] GAS_CO      = 3'd0;
    localparam logic [2:0] GAS_NO2     = 3'd1;
    localparam logic [2:0] GAS_ETHANOL = 3'd2;
    localparam logic [2:0] GAS_H2      = 3'd3;
    localparam logic [2:0] GAS_NH3     = 3'd4;
    localparam logic [2:0] GAS_CH4     = 3'd5;

    // configuration register indexes
    localparam int         CFG_IDX_W     = 2;
    localparam logic [1:0] REG_BASE_RED  = 2'd0;
    localparam logic [1:0] REG_BASE_OX   = 2'd1;
    localparam int         BASE_W        = 24;
    localparam logic [23:0] BASE_RED_RST = 24'd100000;
    localparam logic [23:0] BASE_OX_RST  = 24'd10000;

    // datapath widths
    localparam int RS_W    = 40;  // rs_q8 saturated to this many bits
    localparam int RATIO_W = 24;  // ratio, Q8.16
    localparam int L_W     = 22;  // log2 result, signed Q16
    localparam int B_W     = 20;  // exponent slope, signed Q16
    localparam int LA_W    = 21;  // log2 of the coefficient, signed Q16
    localparam int PROD_W  = L_W + B_W;
    localparam int F_W     = 28;  // exponent argument, signed Q16
    localparam int PPM_W   = 25;
    localparam int SIDE_W  = 4;   // {op, out of range}

    // pipeline depths of the log and exp units
    localparam int LOG_LAT = 17;
    localparam int EXP_LAT = 18;

    localparam logic signed [F_W-1:0] F_OFFSET = 28'sd524288;  // 8.0 in Q16
    localparam logic signed [F_W-1:0] F_LIMIT  = 28'sd1638400; // 25.0 in Q16
    localparam logic [PPM_W-1:0] PPM_FLOOR = 25'd13;
    localparam logic [PPM_W-1:0] PPM_CEIL  = 25'd25600000;

    typedef struct packed {
        logic [RATIO_W-1:0]        lo;
        logic [RATIO_W-1:0]        hi;
        logic signed [LA_W-1:0]    log2a;
        logic signed [B_W-1:0]     b;
        logic [PPM_W-1:0]          min;
        logic [PPM_W-1:0]          max;
        logic                      ox;
    } t_gas_row;

    // per-gas window, power law and clamp limits
    function automatic t_gas_row f_gas_row(input logic [2:0] op);
        t_gas_row row;
        row = '0;
        case (op)
            GAS_CO: begin
                row = '{24'd655, 24'd262144, 21'sd140558, -20'sd77148,
                        25'd256, 25'd256000, 1'b0};
            end
            GAS_NO2: begin
                row = '{24'd19661, 24'd4587520, -21'sd179370, 20'sd65536,
                        25'd13, 25'd2560, 1'b1};
            end
            GAS_ETHANOL: begin
                row = '{24'd1638, 24'd19661, 21'sd41017, -20'sd102801,
                        25'd2560, 25'd128000, 1'b0};
            end
            GAS_H2: begin
                row = '{24'd1114, 24'd58982, -21'sd15785, -20'sd115010,
                        25'd256, 25'd256000, 1'b0};
            end
            GAS_NH3: begin
                row = '{24'd16515, 24'd65536, 21'sd0, -20'sd295409,
                        25'd256, 25'd128000, 1'b0};
            end
            GAS_CH4: begin
                row = '{24'd655, 24'd46858, 21'sd621957, -20'sd274275,
                        25'd256000, 25'd25600000, 1'b0};
            end
            default: begin
                row = '0;
            end
        endcase
        return row;
    endfunction

    // integer square root, evaluated at elaboration only
    function automatic logic [63:0] f_isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] bt;
        logic [63:0] rem;
        r   = '0;
        bt  = 64'd1 << 62;
        rem = v;
        for (int i = 0; i < 32; i++) begin
            if (rem >= r + bt) begin
                rem = rem - (r + bt);
                r   = (r >> 1) + bt;
            end else begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        return r;
    endfunction

    // 2^(2^-k) in Q30
    function automatic logic [63:0] f_exp_factor(input int k);
        logic [63:0] t;
        t = 64'd1 << 31;
        for (int i = 1; i <= k; i++) begin
            t = f_isqrt64(t << 30);
        end
        return t;
    endfunction

endpackage

@@ sv/gas_sensor_ppm_power_law.sv @@
// gas_sensor_ppm_power_law: top level, sample to resistance ratio to ppm
// depends on gspl_pkg, gspl_div, gspl_log2, gspl_exp2
//
// One word (gas selector and converter sample) is taken on every cycle that
// start is high; busy stays low. Each word gives exactly one result on
// o_ppm_q8 / o_in_range, marked by o_valid for one cycle, after 2 entry
// stages, a 41-stage divider for the sensing resistance, a 25-stage divider
// for the baseline ratio, a 17-stage log2, 2 stages for the slope multiply,
// an 18-stage exp2 and one clamp stage. The results come out in order and
// cannot be held off, so the receiver must take every o_valid cycle. The cfg
// port, which is always ready, writes the baselines; the user must do this
// only while no word is in flight, as the block itself does not enforce it.
module gas_sensor_ppm_power_law
    import gspl_pkg::*;
#(
    parameter int ADC_BITS            = 10,
    parameter int MCU_SUPPLY_MV       = 5000,
    parameter int SENSOR_SUPPLY_MV    = 5000,
    parameter int LOAD_REDUCING_OHMS  = 47000,
    parameter int LOAD_OXIDISING_OHMS = 22000
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           i_op,
    input  logic [9:0]           i_adc_sample,
    output logic                 o_valid,
    output logic [PPM_W-1:0]     o_ppm_q8,
    output logic                 o_in_range,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BASE_W-1:0]    i_cfg_data
);

    localparam int ADC_MAX = (1 << ADC_BITS) - 1;
    localparam int SA      = SENSOR_SUPPLY_MV * ADC_MAX;
    localparam int SA_W    = $clog2(SA + 1);
    localparam int D_W     = $clog2(MCU_SUPPLY_MV * 1023 + 1);
    localparam int C_W     = (SA_W > D_W) ? SA_W : D_W;
    localparam int RL_MAX  = (LOAD_REDUCING_OHMS > LOAD_OXIDISING_OHMS) ?
                             LOAD_REDUCING_OHMS : LOAD_OXIDISING_OHMS;
    localparam int RL_W    = $clog2(RL_MAX + 1);
    localparam int X_W     = RL_W + SA_W + 8;
    localparam int LAT     = 2 + (RS_W + 1) + (RATIO_W + 1) + LOG_LAT + 2 + EXP_LAT + 1;

    // baseline registers
    logic [BASE_W-1:0] r_base_red;
    logic [BASE_W-1:0] r_base_ox;

    // entry stage
    logic [D_W-1:0]  n_ma;
    logic            n_a_oor;
    logic            r_a_vld;
    logic [2:0]      r_a_op;
    logic            r_a_oor;
    logic [SA_W-1:0] r_a_num;
    logic [D_W-1:0]  r_a_den;

    // load multiply stage
    t_gas_row        n_b_row;
    logic [RL_W-1:0] n_b_rl;
    logic            r_b_vld;
    logic [2:0]      r_b_op;
    logic            r_b_oor;
    logic [X_W-1:0]  r_b_x;
    logic [D_W-1:0]  r_b_den;

    // divider outputs
    logic              d1_vld;
    logic [RS_W-1:0]   d1_rs;
    logic [SIDE_W-1:0] d1_side;
    t_gas_row          n_d1_row;
    logic [BASE_W-1:0] n_r0;
    logic              d2_vld;
    logic [RATIO_W-1:0] d2_ratio;
    logic [SIDE_W-1:0] d2_side;

    // window test
    t_gas_row          n_w_row;
    logic              n_w_oor;

    // log output and slope stages
    logic                  lg_vld;
    logic signed [L_W-1:0] lg_l;
    logic [SIDE_W-1:0]     lg_side;
    t_gas_row              n_p_row;
    logic                  r_p_vld;
    logic [SIDE_W-1:0]     r_p_side;
    logic signed [PROD_W-1:0] r_p_prod;
    t_gas_row              n_f_row;
    logic signed [25:0]    n_f_q;
    logic                  n_f_adj;
    logic signed [F_W-1:0] n_f;
    logic                  r_f_vld;
    logic [SIDE_W-1:0]     r_f_side;
    logic signed [F_W-1:0] r_f;

    // exp output and clamp
    logic              ex_vld;
    logic [PPM_W-1:0]  ex_pow;
    logic [SIDE_W-1:0] ex_side;
    t_gas_row          n_c_row;
    logic              r_o_vld;
    logic [PPM_W-1:0]  r_o_ppm;
    logic              r_o_rng;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_red <= BASE_RED_RST;
            r_base_ox  <= BASE_OX_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_BASE_RED) begin
                r_base_red <= i_cfg_data;
            end else if (i_cfg_index == REG_BASE_OX) begin
                r_base_ox <= i_cfg_data;
            end
        end
    end

    // voltage difference and divisor
    always_comb begin
        n_ma    = D_W'(MCU_SUPPLY_MV) * D_W'(i_adc_sample);
        n_a_oor = (i_op > GAS_CH4) || (i_adc_sample == '0) ||
                  (C_W'(n_ma) > C_W'(SA));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start && !busy;
        end
        r_a_op  <= i_op;
        r_a_oor <= n_a_oor;
        r_a_num <= SA_W'(SA) - SA_W'(n_ma);
        r_a_den <= n_ma;
    end

    // scaled numerator: load ohms times difference, Q8
    always_comb begin
        n_b_row = f_gas_row(r_a_op);
        n_b_rl  = n_b_row.ox ? RL_W'(LOAD_OXIDISING_OHMS) : RL_W'(LOAD_REDUCING_OHMS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        r_b_op  <= r_a_op;
        r_b_oor <= r_a_oor;
        r_b_x   <= (X_W'(n_b_rl) * X_W'(r_a_num)) << 8;
        r_b_den <= r_a_den;
    end

    // sensing resistance, Q8, saturated
    gspl_div #(
        .NUM_W (X_W),
        .DEN_W (D_W),
        .Q_W   (RS_W),
        .SW    (SIDE_W)
    ) u_div_rs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_b_vld),
        .i_num   (r_b_x),
        .i_den   (r_b_den),
        .i_side  ({r_b_op, r_b_oor}),
        .o_valid (d1_vld),
        .o_quot  (d1_rs),
        .o_side  (d1_side)
    );

    // baseline of the gas's channel
    always_comb begin
        n_d1_row = f_gas_row(d1_side[SIDE_W-1:1]);
        n_r0     = n_d1_row.ox ? r_base_ox : r_base_red;
    end

    // resistance ratio, Q8.16, saturated
    gspl_div #(
        .NUM_W (RS_W + 8),
        .DEN_W (BASE_W),
        .Q_W   (RATIO_W),
        .SW    (SIDE_W)
    ) u_div_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d1_vld),
        .i_num   ({d1_rs, 8'd0}),
        .i_den   (n_r0),
        .i_side  (d1_side),
        .o_valid (d2_vld),
        .o_quot  (d2_ratio),
        .o_side  (d2_side)
    );

    // gas window
    always_comb begin
        n_w_row = f_gas_row(d2_side[SIDE_W-1:1]);
        n_w_oor = d2_side[0] || (d2_ratio < n_w_row.lo) || (d2_ratio > n_w_row.hi);
    end

    gspl_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d2_vld),
        .i_x     (d2_ratio),
        .i_side  ({d2_side[SIDE_W-1:1], n_w_oor}),
        .o_valid (lg_vld),
        .o_l     (lg_l),
        .o_side  (lg_side)
    );

    // slope times log
    always_comb begin
        n_p_row = f_gas_row(lg_side[SIDE_W-1:1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= lg_vld;
        end
        r_p_side <= lg_side;
        r_p_prod <= PROD_W'(n_p_row.b) * PROD_W'(lg_l);
    end

    // truncate toward zero, add log2 of coefficient and the Q8 scale
    always_comb begin
        n_f_row = f_gas_row(r_p_side[SIDE_W-1:1]);
        n_f_q   = r_p_prod[PROD_W-1:16];
        n_f_adj = r_p_prod[PROD_W-1] && (r_p_prod[15:0] != '0);
        n_f     = F_W'(n_f_row.log2a) + F_W'(n_f_q) +
                  F_W'({1'b0, n_f_adj}) + F_OFFSET;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= r_p_vld;
        end
        r_f_side <= r_p_side;
        r_f      <= n_f;
    end

    gspl_exp2 u_exp2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_f_vld),
        .i_f     (r_f),
        .i_side  (r_f_side),
        .o_valid (ex_vld),
        .o_pow   (ex_pow),
        .o_side  (ex_side)
    );

    // clamp to gas limits, zero when out of range
    always_comb begin
        n_c_row = f_gas_row(ex_side[SIDE_W-1:1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= ex_vld;
        end
        r_o_rng <= !ex_side[0];
        if (ex_side[0]) begin
            r_o_ppm <= '0;
        end else if (ex_pow < n_c_row.min) begin
            r_o_ppm <= n_c_row.min;
        end else if (ex_pow > n_c_row.max) begin
            r_o_ppm <= n_c_row.max;
        end else begin
            r_o_ppm <= ex_pow;
        end
    end

    assign o_valid    = r_o_vld;
    assign o_ppm_q8   = r_o_ppm;
    assign o_in_range = r_o_rng;

    // every accepted word comes out after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("accepted word did not produce a result");

    // out-of-range results carry zero
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_in_range) |-> (o_ppm_q8 == '0))
        else $error("out-of-range result with nonzero ppm");

    // valid results lie inside the overall clamp limits
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_in_range) |-> (o_ppm_q8 >= PPM_FLOOR && o_ppm_q8 <= PPM_CEIL))
        else $error("ppm outside clamp limits");

endmodule

@@ sv/gspl_div.sv @@
// gspl_div: pipelined restoring divider, one quotient bit per stage
// quotient saturates to all ones when it does not fit; uses gspl_pkg
module gspl_div
    import gspl_pkg::*;
#(
    parameter int NUM_W = 48,
    parameter int DEN_W = 24,
    parameter int Q_W   = 24,
    parameter int SW    = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [SW-1:0]    i_side,
    output logic             o_valid,
    output logic [Q_W-1:0]   o_quot,
    output logic [SW-1:0]    o_side
);

    localparam int EXT_W = (NUM_W > Q_W) ? NUM_W : Q_W + 1;
    localparam int HI_W  = EXT_W - Q_W;
    localparam int CMP_W = (EXT_W > DEN_W + Q_W) ? EXT_W : DEN_W + Q_W;

    logic [EXT_W-1:0] n_ext;
    logic [HI_W-1:0]  n_hi;
    logic             n_ovf;

    logic             r_vld  [0:Q_W];
    logic [DEN_W-1:0] r_rem  [0:Q_W];
    logic [Q_W-1:0]   r_low  [0:Q_W];
    logic [Q_W-1:0]   r_q    [0:Q_W];
    logic [DEN_W-1:0] r_den  [0:Q_W];
    logic             r_sat  [0:Q_W];
    logic [SW-1:0]    r_side [0:Q_W];

    // overflow check and initial partial remainder
    always_comb begin
        n_ext = EXT_W'(i_num);
        n_hi  = n_ext[EXT_W-1:Q_W];
        n_ovf = CMP_W'(n_ext) >= (CMP_W'(i_den) << Q_W);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_rem[0]  <= DEN_W'(n_hi);
        r_low[0]  <= n_ext[Q_W-1:0];
        r_q[0]    <= '0;
        r_den[0]  <= i_den;
        r_sat[0]  <= n_ovf;
        r_side[0] <= i_side;
    end

    // one trial subtraction per stage
    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        logic [DEN_W:0]   n_trial;
        logic             n_ge;
        logic [DEN_W-1:0] n_rem;

        always_comb begin
            n_trial = {r_rem[s], r_low[s][Q_W-1]};
            n_ge    = n_trial >= {1'b0, r_den[s]};
            n_rem   = n_ge ? DEN_W'(n_trial - {1'b0, r_den[s]}) : DEN_W'(n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= r_vld[s];
            end
            r_rem[s+1]  <= n_rem;
            r_low[s+1]  <= r_low[s] << 1;
            r_q[s+1]    <= {r_q[s][Q_W-2:0], n_ge};
            r_den[s+1]  <= r_den[s];
            r_sat[s+1]  <= r_sat[s];
            r_side[s+1] <= r_side[s];
        end
    end

    assign o_valid = r_vld[Q_W];
    assign o_quot  = r_sat[Q_W] ? {Q_W{1'b1}} : r_q[Q_W];
    assign o_side  = r_side[Q_W];

endmodule

@@ sv/gspl_log2.sv @@
// gspl_log2: pipelined log2 of a Q16 value, one fraction bit per stage
// leading-one normalize, then squaring of the Q30 mantissa; uses gspl_pkg
module gspl_log2
    import gspl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [RATIO_W-1:0]    i_x,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_valid,
    output logic signed [L_W-1:0] o_l,
    output logic [SIDE_W-1:0]     o_side
);

    localparam int STG = 16;

    logic [4:0]  n_p;
    logic [30:0] n_m;

    logic              r_vld  [0:STG];
    logic [30:0]       r_m    [0:STG];
    logic [15:0]       r_frac [0:STG];
    logic [4:0]        r_p    [0:STG];
    logic [SIDE_W-1:0] r_side [0:STG];

    // leading one and normalize to [1,2) in Q30
    always_comb begin
        n_p = '0;
        for (int i = 0; i < RATIO_W; i++) begin
            if (i_x[i]) begin
                n_p = 5'(i);
            end
        end
        n_m = 31'(i_x) << (5'd30 - n_p);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_m[0]    <= n_m;
        r_frac[0] <= '0;
        r_p[0]    <= n_p;
        r_side[0] <= i_side;
    end

    // square, take one fraction bit
    for (genvar k = 0; k < STG; k++) begin : g_sq
        logic [61:0] n_sq;
        logic [31:0] n_sh;

        always_comb begin
            n_sq = 62'(r_m[k]) * 62'(r_m[k]);
            n_sh = n_sq[61:30];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            r_m[k+1]    <= n_sh[31] ? n_sh[31:1] : n_sh[30:0];
            r_frac[k+1] <= {r_frac[k][14:0], n_sh[31]};
            r_p[k+1]    <= r_p[k];
            r_side[k+1] <= r_side[k];
        end
    end

    assign o_valid = r_vld[STG];
    assign o_l     = {6'({1'b0, r_p[STG]}) - 6'd16, r_frac[STG]};
    assign o_side  = r_side[STG];

endmodule

@@ sv/gspl_exp2.sv @@
// gspl_exp2: pipelined 2^F for a signed Q16 argument, result in Q0
// one constant factor 2^(2^-k) per stage; uses gspl_pkg
module gspl_exp2
    import gspl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic signed [F_W-1:0] i_f,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_valid,
    output logic [PPM_W-1:0]      o_pow,
    output logic [SIDE_W-1:0]     o_side
);

    localparam int STG = 16;

    logic              r_vld  [0:STG];
    logic [30:0]       r_m    [0:STG];
    logic [15:0]       r_fr   [0:STG];
    logic [4:0]        r_n    [0:STG];
    logic              r_neg  [0:STG];
    logic              r_big  [0:STG];
    logic [SIDE_W-1:0] r_side [0:STG];

    logic              r_o_vld;
    logic [PPM_W-1:0]  r_o_pow;
    logic [SIDE_W-1:0] r_o_side;

    // range split and integer part
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_m[0]    <= 31'd1 << 30;
        r_fr[0]   <= i_f[15:0];
        r_n[0]    <= i_f[20:16];
        r_neg[0]  <= i_f[F_W-1];
        r_big[0]  <= i_f >= F_LIMIT;
        r_side[0] <= i_side;
    end

    // multiply in one factor per fraction bit
    for (genvar k = 0; k < STG; k++) begin : g_mul
        localparam logic [30:0] TK = 31'(f_exp_factor(k + 1));
        logic [61:0] n_prod;

        always_comb begin
            n_prod = 62'(r_m[k]) * 62'(TK);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            r_m[k+1]    <= r_fr[k][STG-1-k] ? n_prod[60:30] : r_m[k];
            r_fr[k+1]   <= r_fr[k];
            r_n[k+1]    <= r_n[k];
            r_neg[k+1]  <= r_neg[k];
            r_big[k+1]  <= r_big[k];
            r_side[k+1] <= r_side[k];
        end
    end

    // final scale and saturation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_vld[STG];
        end
        if (r_neg[STG]) begin
            r_o_pow <= '0;
        end else if (r_big[STG]) begin
            r_o_pow <= {PPM_W{1'b1}};
        end else begin
            r_o_pow <= PPM_W'(r_m[STG] >> (5'd30 - r_n[STG]));
        end
        r_o_side <= r_side[STG];
    end

    assign o_valid = r_o_vld;
    assign o_pow   = r_o_pow;
    assign o_side  = r_o_side;

endmodule

@@ sim/tb_gas_sensor_ppm_power_law.sv @@
// tb_gas_sensor_ppm_power_law: self-checking bench for the gas ppm power-law block
// depends on gspl_pkg and gas_sensor_ppm_power_law; predicts each result in-bench
`timescale 1ns / 1ps

module tb_gas_sensor_ppm_power_law;
    import gspl_pkg::*;

    localparam int ADC_MAX = 1023;
    localparam int VSUP    = 5000;
    localparam int VMCU    = 5000;
    localparam int RL_RED  = 47000;
    localparam int RL_OX   = 22000;
    localparam int DRAIN   = 130;

    typedef struct {
        logic [2:0] op;
        logic [9:0] adc;
    } t_word;

    typedef struct {
        logic [PPM_W-1:0] ppm;
        logic             rng;
    } t_conc;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [2:0]           i_op = '0;
    logic [9:0]           i_adc_sample = '0;
    logic                 o_valid;
    logic [PPM_W-1:0]     o_ppm_q8;
    logic                 o_in_range;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [BASE_W-1:0]    i_cfg_data = '0;

    t_word     word_q[$];
    t_conc     conc_q[$];
    int        idle_pct = 0;
    bit        hold = 1'b0;
    int        errors = 0;
    longint    base_red = 100000;
    longint    base_ox = 10000;
    longint    exp_fac[1:16];

    // per-gas window, power law and clamp
    longint lo_t[6]  = '{655, 19661, 1638, 1114, 16515, 655};
    longint hi_t[6]  = '{262144, 4587520, 19661, 58982, 65536, 46858};
    longint la_t[6]  = '{140558, -179370, 41017, -15785, 0, 621957};
    longint b_t[6]   = '{-77148, 65536, -102801, -115010, -295409, -274275};
    longint mn_t[6]  = '{256, 13, 2560, 256, 256, 256000};
    longint mx_t[6]  = '{256000, 2560, 128000, 256000, 128000, 25600000};

    gas_sensor_ppm_power_law u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_op(i_op), .i_adc_sample(i_adc_sample), .o_valid(o_valid),
        .o_ppm_q8(o_ppm_q8), .o_in_range(o_in_range), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic longint root64(input longint unsigned v);
        longint unsigned r, bt;
        r = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= r + bt) begin
                v = v - (r + bt);
                r = (r >> 1) + bt;
            end else begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        return r;
    endfunction

    // log2 of a Q16 ratio, Q16 result
    function automatic longint ratio_log2(input longint x);
        int p;
        longint m, frac;
        p = 0;
        frac = 0;
        while ((x >> (p + 1)) != 0) p++;
        m = x << (30 - p);
        for (int i = 1; i <= 16; i++) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                frac = frac | (64'd1 << (16 - i));
            end
        end
        return longint'(p - 16) * 65536 + frac;
    endfunction

    // 2^f for Q16 f, capped at 25 bits
    function automatic longint pow2_q16(input longint f);
        longint n, m;
        m = 64'd1 << 30;
        if (f < 0) return 0;
        if (f >= 25 * 65536) return 33554431;
        n = f >> 16;
        for (int k = 1; k <= 16; k++) begin
            if ((f >> (16 - k)) & 1) m = (m * exp_fac[k]) >> 30;
        end
        return m >> (30 - n);
    endfunction

    function automatic t_conc gas_conc(input logic [2:0] op, input logic [9:0] adc);
        t_conc  c;
        longint a, num, den, rl, r0, rs, ratio, e, ppm;
        c.ppm = '0;
        c.rng = 1'b0;
        a = adc;
        if (op > GAS_CH4 || a == 0) return c;
        num = longint'(VSUP) * ADC_MAX - longint'(VMCU) * a;
        if (num < 0) return c;
        den = longint'(VMCU) * a;
        rl = (op == GAS_NO2) ? RL_OX : RL_RED;
        r0 = (op == GAS_NO2) ? base_ox : base_red;
        rs = (rl * num * 256) / den;
        if (r0 == 0) ratio = 24'hFFFFFF;
        else begin
            ratio = (rs * 256) / r0;
            if (ratio > 24'hFFFFFF) ratio = 24'hFFFFFF;
        end
        if (ratio < lo_t[op] || ratio > hi_t[op]) return c;
        e = la_t[op] + (b_t[op] * ratio_log2(ratio)) / 65536;
        ppm = pow2_q16(e + 8 * 65536);
        if (ppm < mn_t[op]) ppm = mn_t[op];
        if (ppm > mx_t[op]) ppm = mx_t[op];
        c.ppm = ppm[PPM_W-1:0];
        c.rng = 1'b1;
        return c;
    endfunction

    // word driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                conc_q.push_back(gas_conc(i_op, i_adc_sample));
                void'(word_q.pop_front());
            end
            if (word_q.size() > 0 && !hold && $urandom_range(99) >= idle_pct) begin
                start <= 1'b1;
                i_op <= word_q[0].op;
                i_adc_sample <= word_q[0].adc;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_conc ex;
        if (i_rst_n && o_valid) begin
            if (conc_q.size() == 0) begin
                $display("%0t: unexpected result ppm=%0d in_range=%0b",
                         $time, o_ppm_q8, o_in_range);
                errors++;
            end else begin
                ex = conc_q.pop_front();
                if (o_ppm_q8 !== ex.ppm) begin
                    $display("%0t: ppm_q8 expected %0d actual %0d", $time, ex.ppm, o_ppm_q8);
                    errors++;
                end
                if (o_in_range !== ex.rng) begin
                    $display("%0t: in_range expected %0b actual %0b",
                             $time, ex.rng, o_in_range);
                    errors++;
                end
            end
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [BASE_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        i_cfg_valid <= 1'b0;
        if (idx == REG_BASE_RED) base_red = val;
        else if (idx == REG_BASE_OX) base_ox = val;
    endtask

    task automatic push_word(input logic [2:0] op, input logic [9:0] adc);
        t_word w;
        w.op = op;
        w.adc = adc;
        word_q.push_back(w);
    endtask

    task automatic drain();
        while (word_q.size() != 0 || start || conc_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic push_random(input int n);
        logic [2:0] op;
        for (int i = 0; i < n; i++) begin
            op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
            push_word(op, 10'($urandom_range(ADC_MAX)));
        end
    endtask

    initial begin
        logic [BASE_W-1:0] reds[6];
        logic [BASE_W-1:0] oxs[6];
        for (int k = 1; k <= 16; k++)
            exp_fac[k] = root64(((k == 1) ? (64'd1 << 31) : exp_fac[k-1]) << 30);
        reds = '{24'd100000, 24'd1, 24'hFFFFFF, 24'd30000, 24'd400000, 24'd5000};
        oxs  = '{24'd10000, 24'hFFFFFF, 24'd1, 24'd3000, 24'd60000, 24'd800};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every selector at zero, one and full scale
        for (int op = 0; op < 8; op++) begin
            push_word(3'(op), 10'd0);
            push_word(3'(op), 10'd1);
            push_word(3'(op), 10'(ADC_MAX));
        end
        drain();
        // ignored register index
        cfg_write(2'd2, 24'd12345);
        cfg_write(2'd3, 24'd0);

        for (int ph = 0; ph < 6; ph++) begin
            idle_pct = (ph < 2) ? 23 : (ph < 4) ? 87 : 0;
            cfg_write(REG_BASE_RED, reds[ph]);
            cfg_write(REG_BASE_OX, oxs[ph]);
            push_random(130);
            // sender pauses until everything in flight has come back
            if (ph == 1) begin
                while (word_q.size() != 0) @(posedge i_clk);
                hold = 1'b1;
                while (start || conc_q.size() != 0) @(posedge i_clk);
                hold = 1'b0;
            end
            push_random(135);
            drain();
        end

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // run limit
    initial begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
